>>> hdl/fwp_pkg.sv
`timescale 1ns / 1ps
package fwp_pkg;

  localparam int PAYLOAD_DEPTH = 32;
  localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);

  // Scan positions: start at 3, at most 15 steps to '=', one past it,
  // six copied characters, the '.', and one more digit: 26 at most.
  localparam int SCAN_START = 3;
  localparam int STEP_LIMIT = 15;
  localparam int COPY_LIMIT = 6;
  localparam int POS_MAX = SCAN_START + STEP_LIMIT + COPY_LIMIT + 2;
  localparam int POS_W = $clog2(POS_MAX + 1);
  localparam int STEP_W = $clog2(STEP_LIMIT + 1);
  localparam int COPY_W = $clog2(COPY_LIMIT + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic ACT_RECEIVE = 1'b0;
  localparam logic ACT_CLEAR   = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic       framing_error;
    logic       sync_error;
  } item_t;

  typedef struct packed {
    logic               sample_done;
    logic signed [15:0] speed_tenths;
    logic signed [31:0] speed_total;
    logic [31:0]        square_total;
    logic signed [31:0] cube_total;
    logic signed [15:0] speed_peak;
    logic [15:0]        sample_count;
  } result_t;

  typedef struct packed {
    logic signed [15:0] last_speed;
    logic [31:0]        speed_accum;
    logic [31:0]        square_accum;
    logic [31:0]        cube_accum;
    logic signed [15:0] peak_speed;
    logic [15:0]        samples_seen;
  } stats_t;

  typedef struct packed {
    logic clear;
    logic start;
  } stats_ctl_t;

endpackage

>>> hdl/fwp_store.sv
`timescale 1ns / 1ps
module fwp_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [fwp_pkg::ADDR_W-1:0] wr_addr,
  input  logic [7:0]                 wr_data,
  input  logic                       rd_en,
  input  logic [fwp_pkg::POS_W-1:0]  rd_pos,
  output logic [7:0]                 rd_data
);

  logic [7:0] mem [fwp_pkg::PAYLOAD_DEPTH];
  logic [fwp_pkg::PAYLOAD_DEPTH-1:0] written;
  logic [fwp_pkg::ADDR_W-1:0] rd_idx;
  logic in_range;
  logic [7:0] rd_q;
  logic rd_ok;

  assign rd_idx   = fwp_pkg::ADDR_W'(rd_pos);
  assign in_range = int'(rd_pos) < fwp_pkg::PAYLOAD_DEPTH;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  // Entries never written since reset, and positions past the end, read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= in_range && written[rd_idx];
      end
    end
  end

  assign rd_data = rd_ok ? rd_q : 8'h00;

endmodule

>>> hdl/fwp_stats.sv
`timescale 1ns / 1ps
module fwp_stats (
  input  logic                clk,
  input  logic                rst,
  input  fwp_pkg::stats_ctl_t ctl,
  input  logic signed [15:0]  speed,
  output logic                busy,
  output logic                done,
  output fwp_pkg::stats_t     stats
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_SQUARE,
    T_CUBE
  } tstate_t;

  tstate_t st;
  logic [31:0] s32;
  logic [31:0] sq;
  logic [31:0] mul_a;
  logic [31:0] product;

  // One multiplier serves both the square and the cube.
  assign mul_a   = (st == T_CUBE) ? sq : s32;
  assign product = mul_a * s32;
  assign busy    = (st != T_IDLE);
  assign done    = (st == T_CUBE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= T_IDLE;
      stats <= '0;
    end else begin
      unique case (st)
        T_IDLE: begin
          if (ctl.clear) begin
            stats <= '0;
          end else if (ctl.start) begin
            s32 <= 32'(speed);
            st  <= T_SQUARE;
          end
        end
        T_SQUARE: begin
          sq                 <= product;
          stats.last_speed   <= s32[15:0];
          stats.speed_accum  <= stats.speed_accum + s32;
          stats.square_accum <= stats.square_accum + product;
          if (stats.samples_seen == 16'd0 || $signed(s32[15:0]) > stats.peak_speed) begin
            stats.peak_speed <= s32[15:0];
          end
          stats.samples_seen <= stats.samples_seen + 16'd1;
          st                 <= T_CUBE;
        end
        T_CUBE: begin
          stats.cube_accum <= stats.cube_accum + product;
          st               <= T_IDLE;
        end
        default: begin
          st <= T_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/wind_frame_parser_statistics.sv
`timescale 1ns / 1ps
// Wind sensor frame parser with speed statistics.
// The item channel (item_valid, item_ready, item) carries one received byte
// with its framing and sync flags, or a clear of all statistics. The result
// channel (result_valid, result_ready, result) returns exactly one transfer
// per item: the current statistics and a flag telling whether this byte
// closed a frame and produced a new sample.
// An ordinary byte or a clear moves the sequencer to S_RESULT, which loads
// the result register; no new item is taken before that. The LF that
// closes a frame starts a walk over the payload store through its single
// registered read port: up to 16 reads looking for '=', up to 7 reads
// copying the speed text, and one last read, followed by the square and
// the cube in the shared multiplier, and then by the load of its result.
// Only one item is in work at a time; item_ready is high while the
// sequencer is idle, also while a finished result waits for the receiver.
// A stalled receiver holds the result register, and the next item's result
// waits inside the block until that register is free.
// Reset clears the parser, the statistics and the store (through per-entry
// valid bits).
module wind_frame_parser_statistics (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  fwp_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output fwp_pkg::result_t result
);

  typedef enum logic [2:0] {
    P_WAIT_ZERO,
    P_WAIT_R,
    P_WAIT_ONE,
    P_WAIT_COMMA,
    P_BODY,
    P_WAIT_LF
  } pstate_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EQ_RD,
    S_EQ_CHK,
    S_CP_RD,
    S_CP_CHK,
    S_LAST_RD,
    S_LAST_CHK,
    S_STATS,
    S_RESULT
  } sstate_t;

  typedef enum logic [1:0] {
    A_SKIP,
    A_DIGITS,
    A_STOP
  } astate_t;

  pstate_t pst, pst_next;
  sstate_t st;
  astate_t aph, aph_f;

  logic [fwp_pkg::ADDR_W-1:0] widx, widx_next;
  logic [fwp_pkg::POS_W-1:0]  pos;
  logic [fwp_pkg::STEP_W-1:0] steps;
  logic [fwp_pkg::COPY_W-1:0] ncopy;
  logic [15:0] acc, acc_f;
  logic        neg, neg_f;
  logic        sample_flag;

  logic        accept;
  logic        rx_active;
  logic        frame_end;
  logic        wr_en;
  logic        rd_en;
  logic [7:0]  rd_data;
  logic        is_digit;
  logic        is_blank;
  logic [15:0] digit;
  logic [15:0] speed_val;

  fwp_pkg::stats_ctl_t stats_ctl;
  fwp_pkg::stats_t     stats;
  logic                stats_busy;
  logic                stats_done;

  assign accept    = item_valid && item_ready;
  assign item_ready = (st == S_IDLE);
  assign rx_active = accept && (item.action == fwp_pkg::ACT_RECEIVE) && !item.sync_error;

  // Parser transition for one received byte.
  always_comb begin
    pst_next  = pst;
    widx_next = widx;
    frame_end = 1'b0;
    wr_en     = 1'b0;
    unique case (pst)
      P_WAIT_ZERO: begin
        if (item.rx_byte == fwp_pkg::CH_ZERO) pst_next = P_WAIT_R;
      end
      P_WAIT_R: begin
        pst_next = (item.rx_byte == fwp_pkg::CH_R) ? P_WAIT_ONE : P_WAIT_ZERO;
        if (item.rx_byte != fwp_pkg::CH_R) widx_next = '0;
      end
      P_WAIT_ONE: begin
        pst_next = (item.rx_byte == fwp_pkg::CH_ONE) ? P_WAIT_COMMA : P_WAIT_ZERO;
        if (item.rx_byte != fwp_pkg::CH_ONE) widx_next = '0;
      end
      P_WAIT_COMMA: begin
        pst_next = (item.rx_byte == fwp_pkg::CH_COMMA) ? P_BODY : P_WAIT_ZERO;
        if (item.rx_byte != fwp_pkg::CH_COMMA) widx_next = '0;
      end
      P_BODY: begin
        if (item.rx_byte == fwp_pkg::CH_CR) begin
          pst_next = P_WAIT_LF;
        end else begin
          wr_en = rx_active;
          // Filling the last entry overflows the buffer and restarts the parser.
          if (widx == fwp_pkg::ADDR_W'(fwp_pkg::PAYLOAD_DEPTH - 1)) begin
            pst_next  = P_WAIT_ZERO;
            widx_next = '0;
          end else begin
            widx_next = widx + 1'b1;
          end
        end
      end
      P_WAIT_LF: begin
        frame_end = (item.rx_byte == fwp_pkg::CH_LF);
        pst_next  = P_WAIT_ZERO;
        widx_next = '0;
      end
      default: begin
        pst_next  = P_WAIT_ZERO;
        widx_next = '0;
      end
    endcase
    if (item.framing_error) begin
      pst_next  = P_WAIT_ZERO;
      widx_next = '0;
    end
  end

  // Streaming text-to-number conversion, one character per call.
  assign is_digit = (rd_data >= fwp_pkg::CH_ZERO) && (rd_data <= fwp_pkg::CH_NINE);
  assign is_blank = (rd_data == fwp_pkg::CH_SPACE) ||
                    ((rd_data >= fwp_pkg::CH_TAB) && (rd_data <= fwp_pkg::CH_CR));
  assign digit    = {12'h000, rd_data[3:0]};

  always_comb begin
    aph_f = aph;
    acc_f = acc;
    neg_f = neg;
    unique case (aph)
      A_SKIP: begin
        if (is_blank) begin
          aph_f = A_SKIP;
        end else if (rd_data == fwp_pkg::CH_PLUS) begin
          aph_f = A_DIGITS;
        end else if (rd_data == fwp_pkg::CH_MINUS) begin
          aph_f = A_DIGITS;
          neg_f = 1'b1;
        end else if (is_digit) begin
          aph_f = A_DIGITS;
          acc_f = digit;
        end else begin
          aph_f = A_STOP;
        end
      end
      A_DIGITS: begin
        if (is_digit) begin
          acc_f = (acc << 3) + (acc << 1) + digit;
        end else begin
          aph_f = A_STOP;
        end
      end
      A_STOP: begin
        aph_f = A_STOP;
      end
      default: begin
        aph_f = A_STOP;
      end
    endcase
  end

  assign speed_val = neg_f ? (16'd0 - acc_f) : acc_f;

  assign rd_en = (st == S_EQ_RD) || (st == S_CP_RD) || (st == S_LAST_RD);

  assign stats_ctl.clear = accept && (item.action == fwp_pkg::ACT_CLEAR);
  assign stats_ctl.start = (st == S_LAST_CHK);

  fwp_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (widx),
    .wr_data (item.rx_byte),
    .rd_en   (rd_en),
    .rd_pos  (pos),
    .rd_data (rd_data)
  );

  fwp_stats u_stats (
    .clk   (clk),
    .rst   (rst),
    .ctl   (stats_ctl),
    .speed (speed_val),
    .busy  (stats_busy),
    .done  (stats_done),
    .stats (stats)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pst          <= P_WAIT_ZERO;
      widx         <= '0;
      st           <= S_IDLE;
      sample_flag  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // In S_RESULT the result register is either reloaded or left waiting.
      if (st != S_RESULT && result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (accept) begin
            sample_flag <= 1'b0;
            st          <= S_RESULT;
            if (rx_active) begin
              pst  <= pst_next;
              widx <= widx_next;
              if (frame_end && !item.framing_error) begin
                sample_flag <= 1'b1;
                pos         <= fwp_pkg::POS_W'(fwp_pkg::SCAN_START);
                steps       <= '0;
                st          <= S_EQ_RD;
              end
            end
          end
        end
        S_EQ_RD: begin
          st <= S_EQ_CHK;
        end
        S_EQ_CHK: begin
          pos <= pos + 1'b1;
          if (rd_data == fwp_pkg::CH_EQUAL ||
              steps == fwp_pkg::STEP_W'(fwp_pkg::STEP_LIMIT)) begin
            ncopy <= '0;
            aph   <= A_SKIP;
            acc   <= '0;
            neg   <= 1'b0;
            st    <= S_CP_RD;
          end else begin
            steps <= steps + 1'b1;
            st    <= S_EQ_RD;
          end
        end
        S_CP_RD: begin
          st <= S_CP_CHK;
        end
        S_CP_CHK: begin
          pos <= pos + 1'b1;
          if (rd_data == fwp_pkg::CH_DOT ||
              ncopy == fwp_pkg::COPY_W'(fwp_pkg::COPY_LIMIT)) begin
            st <= S_LAST_RD;
          end else begin
            aph   <= aph_f;
            acc   <= acc_f;
            neg   <= neg_f;
            ncopy <= ncopy + 1'b1;
            st    <= S_CP_RD;
          end
        end
        S_LAST_RD: begin
          st <= S_LAST_CHK;
        end
        S_LAST_CHK: begin
          st <= S_STATS;
        end
        S_STATS: begin
          if (stats_done) begin
            st <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!result_valid || result_ready) begin
            result_valid        <= 1'b1;
            result.sample_done  <= sample_flag;
            result.speed_tenths <= stats.last_speed;
            result.speed_total  <= stats.speed_accum;
            result.square_total <= stats.square_accum;
            result.cube_total   <= stats.cube_accum;
            result.speed_peak   <= stats.peak_speed;
            result.sample_count <= stats.samples_seen;
            st                  <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  // The scan never walks past the last position a frame can reach.
  assert property (@(posedge clk) disable iff (rst)
    st != S_IDLE |-> int'(pos) <= fwp_pkg::POS_MAX)
    else $error("scan position beyond its bound");

  // At most six characters are copied before the digit after the point.
  assert property (@(posedge clk) disable iff (rst)
    int'(ncopy) <= fwp_pkg::COPY_LIMIT || st == S_IDLE || st == S_EQ_RD || st == S_EQ_CHK)
    else $error("copy count beyond its bound");

  // No item is taken while the multiplier is still working on a sample.
  assert property (@(posedge clk) disable iff (rst)
    accept |-> !stats_busy)
    else $error("item accepted while statistics unit is busy");

  // A result that reports a new sample is loaded only after the statistics update.
  assert property (@(posedge clk) disable iff (rst)
    (st == S_RESULT && sample_flag) |-> $past(st == S_STATS) || $past(st == S_RESULT))
    else $error("sample result loaded without a statistics update");

endmodule
